FILE: hdl/swsr_pkg.sv
// shared types and constants for the single-wire sensor reader
`default_nettype none

package swsr_pkg;

  // field widths
  localparam int unsigned LowTicksW  = 21;
  localparam int unsigned ShortTicksW = 10;
  localparam int unsigned ByteCountW = 4;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 21;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_START_LOW    = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_START_HIGH   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_RESP_FIRST   = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_RESP_SECOND  = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_BIT_SAMPLE   = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_BYTES_PER_RD = 3'd5;

  // configuration reset values
  localparam logic [LowTicksW-1:0]   RST_START_LOW   = 21'd1200000;
  localparam logic [ShortTicksW-1:0] RST_START_HIGH  = 10'd30;
  localparam logic [ShortTicksW-1:0] RST_RESP_FIRST  = 10'd40;
  localparam logic [ShortTicksW-1:0] RST_RESP_SECOND = 10'd80;
  localparam logic [ShortTicksW-1:0] RST_BIT_SAMPLE  = 10'd40;
  localparam logic [ByteCountW-1:0]  RST_BYTES       = 4'd5;

  // line drive codes
  localparam logic [1:0] DRIVE_RELEASE = 2'd0;
  localparam logic [1:0] DRIVE_LOW     = 2'd1;
  localparam logic [1:0] DRIVE_HIGH    = 2'd2;

  // response status codes
  localparam logic [1:0] RESP_NONE = 2'd0;
  localparam logic [1:0] RESP_OK   = 2'd1;
  localparam logic [1:0] RESP_BAD  = 2'd2;

  // transaction phases
  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_START_LOW     = 4'd1,
    PH_START_HIGH    = 4'd2,
    PH_RESP_FIRST    = 4'd3,
    PH_RESP_SECOND   = 4'd4,
    PH_RESP_WAIT_LOW = 4'd5,
    PH_BIT_WAIT_HIGH = 4'd6,
    PH_BIT_DELAY     = 4'd7,
    PH_BIT_WAIT_LOW  = 4'd8
  } phase_e;

  // configuration register set
  typedef struct packed {
    logic [LowTicksW-1:0]   start_low_ticks;
    logic [ShortTicksW-1:0] start_high_ticks;
    logic [ShortTicksW-1:0] response_first_ticks;
    logic [ShortTicksW-1:0] response_second_ticks;
    logic [ShortTicksW-1:0] bit_sample_ticks;
    logic [ByteCountW-1:0]  bytes_per_read;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [1:0] line_drive;
    logic       status_valid;
    logic [1:0] response_status;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       last_byte;
    logic       busy_res;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/swsr_core.sv
// protocol state and per-tick step logic of the sensor reader
`default_nettype none

module swsr_core #(
  parameter int unsigned MAX_BYTES = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            start_i,
  input  wire logic            line_i,
  input  wire swsr_pkg::cfg_t  cfg_i,
  output swsr_pkg::res_t       res_o
);
  import swsr_pkg::*;

  localparam int unsigned ByteIdxW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES + 1) : 1;
  localparam int unsigned TotalW   = ByteCountW + 1;

  phase_e                 phase_q, phase_d;
  logic [LowTicksW-1:0]   tick_q, tick_d;
  logic [2:0]             bit_q, bit_d;
  logic [7:0]             shift_q, shift_d;
  logic [ByteIdxW-1:0]    byte_q, byte_d;

  phase_e                 ph;
  logic [LowTicksW-1:0]   tc;
  logic [2:0]             bi;
  logic [7:0]             sb;
  logic [ByteIdxW-1:0]    byi;
  logic [LowTicksW-1:0]   lim;
  logic [LowTicksW-1:0]   lim_eff;
  logic [LowTicksW-1:0]   tc_inc;
  logic                   done;
  logic [TotalW-1:0]      total;
  logic [TotalW-1:0]      byi_inc;

  // bytes per transaction, clamped to one through MAX_BYTES
  always_comb begin
    if (cfg_i.bytes_per_read == '0) begin
      total = TotalW'(1);
    end else if (TotalW'(cfg_i.bytes_per_read) > TotalW'(MAX_BYTES)) begin
      total = TotalW'(MAX_BYTES);
    end else begin
      total = TotalW'(cfg_i.bytes_per_read);
    end
  end

  // one tick of the protocol
  always_comb begin
    ph  = phase_q;
    tc  = tick_q;
    bi  = bit_q;
    sb  = shift_q;
    byi = byte_q;
    res_o = '0;

    // start only from idle
    if (ph == PH_IDLE && start_i) begin
      ph  = PH_START_LOW;
      tc  = '0;
      bi  = '0;
      sb  = '0;
      byi = '0;
    end
    res_o.busy_res = (ph != PH_IDLE);

    // delay limit of the current phase, zero acts as one
    unique case (ph)
      PH_START_LOW:   lim = cfg_i.start_low_ticks;
      PH_START_HIGH:  lim = LowTicksW'(cfg_i.start_high_ticks);
      PH_RESP_FIRST:  lim = LowTicksW'(cfg_i.response_first_ticks);
      PH_RESP_SECOND: lim = LowTicksW'(cfg_i.response_second_ticks);
      default:        lim = LowTicksW'(cfg_i.bit_sample_ticks);
    endcase
    lim_eff = (lim == '0) ? LowTicksW'(1) : lim;
    tc_inc  = tc + LowTicksW'(1);
    done    = (tc_inc >= lim_eff);
    byi_inc = TotalW'(byi) + TotalW'(1);

    phase_d = ph;
    tick_d  = tc;
    bit_d   = bi;
    shift_d = sb;
    byte_d  = byi;

    unique case (ph)
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      PH_START_LOW: begin
        res_o.line_drive = DRIVE_LOW;
        tick_d = done ? '0 : tc_inc;
        if (done) phase_d = PH_START_HIGH;
      end
      PH_START_HIGH: begin
        res_o.line_drive = DRIVE_HIGH;
        tick_d = done ? '0 : tc_inc;
        if (done) phase_d = PH_RESP_FIRST;
      end
      PH_RESP_FIRST: begin
        tick_d = done ? '0 : tc_inc;
        if (done) begin
          if (!line_i) begin
            phase_d = PH_RESP_SECOND;
          end else begin
            res_o.status_valid    = 1'b1;
            res_o.response_status = RESP_NONE;
            phase_d = PH_RESP_WAIT_LOW;
          end
        end
      end
      PH_RESP_SECOND: begin
        tick_d = done ? '0 : tc_inc;
        if (done) begin
          res_o.status_valid    = 1'b1;
          res_o.response_status = line_i ? RESP_OK : RESP_BAD;
          phase_d = PH_RESP_WAIT_LOW;
        end
      end
      PH_RESP_WAIT_LOW: begin
        if (!line_i) phase_d = PH_BIT_WAIT_HIGH;
      end
      PH_BIT_WAIT_HIGH: begin
        if (line_i) begin
          phase_d = PH_BIT_DELAY;
          tick_d  = '0;
        end
      end
      PH_BIT_DELAY: begin
        tick_d = done ? '0 : tc_inc;
        if (done) begin
          shift_d[3'd7 - bi] = line_i;
          phase_d = PH_BIT_WAIT_LOW;
        end
      end
      PH_BIT_WAIT_LOW: begin
        if (!line_i) begin
          if (bi == 3'd7) begin
            res_o.byte_valid = 1'b1;
            res_o.byte_data  = sb;
            bit_d = '0;
            if (byi_inc >= total) begin
              res_o.last_byte = 1'b1;
              phase_d = PH_IDLE;
              byte_d  = '0;
            end else begin
              byte_d  = ByteIdxW'(byi_inc);
              phase_d = PH_BIT_WAIT_HIGH;
            end
          end else begin
            bit_d   = bi + 3'd1;
            phase_d = PH_BIT_WAIT_HIGH;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // state registers advance once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      byte_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      byte_q  <= byte_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/single_wire_sensor_reader_unit.sv
// top level of the single-wire sensor reader: item registers and config registers
//
// channel   direction  handshake                   payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: start_request, line_level
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata, tlast = last_byte
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// one item per clock cycle sustained while the result side is ready; each item passes
// through the input register, then the step logic into the result register
// reset clears the protocol state and loads the default timing registers
// a stalled result holds the result register and then the input register;
// config writes are always taken
`default_nettype none

module single_wire_sensor_reader_unit #(
  parameter int unsigned MAX_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] start_request, [1] line_level
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [1:0] line_drive, [2] status_valid,
                                           // [4:3] response_status, [5] byte_valid,
                                           // [13:6] byte_data, [14] busy_res
  output logic             m_axis_tlast,   // last_byte
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [swsr_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [swsr_pkg::CfgDataW-1:0]  cfg_data_i
);
  import swsr_pkg::*;

  cfg_t  cfg_q;
  logic  in_valid_q;
  logic  in_start_q;
  logic  in_line_q;
  logic  out_valid_q;
  res_t  out_q;
  res_t  res;
  logic  advance;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks       <= RST_START_LOW;
      cfg_q.start_high_ticks      <= RST_START_HIGH;
      cfg_q.response_first_ticks  <= RST_RESP_FIRST;
      cfg_q.response_second_ticks <= RST_RESP_SECOND;
      cfg_q.bit_sample_ticks      <= RST_BIT_SAMPLE;
      cfg_q.bytes_per_read        <= RST_BYTES;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_LOW:    cfg_q.start_low_ticks       <= cfg_data_i[LowTicksW-1:0];
        CFG_START_HIGH:   cfg_q.start_high_ticks      <= cfg_data_i[ShortTicksW-1:0];
        CFG_RESP_FIRST:   cfg_q.response_first_ticks  <= cfg_data_i[ShortTicksW-1:0];
        CFG_RESP_SECOND:  cfg_q.response_second_ticks <= cfg_data_i[ShortTicksW-1:0];
        CFG_BIT_SAMPLE:   cfg_q.bit_sample_ticks      <= cfg_data_i[ShortTicksW-1:0];
        CFG_BYTES_PER_RD: cfg_q.bytes_per_read        <= cfg_data_i[ByteCountW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow: an item moves on when the result register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_start_q <= s_axis_tdata[0];
      in_line_q  <= s_axis_tdata[1];
    end
  end

  // protocol step
  swsr_core #(
    .MAX_BYTES(MAX_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .start_i(in_start_q),
    .line_i (in_line_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last_byte;
  assign m_axis_tdata  = {1'b0, out_q.busy_res, out_q.byte_data, out_q.byte_valid,
                          out_q.response_status, out_q.status_valid, out_q.line_drive};

  // the line is only driven inside a transaction
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.line_drive != DRIVE_RELEASE) |-> out_q.busy_res)
    else $error("line driven outside a transaction");

  // status and byte never complete on the same tick
  a_status_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.status_valid && out_q.byte_valid))
    else $error("status and byte in the same item");

  // the final byte flag comes only with a byte
  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last_byte |-> out_q.byte_valid && out_q.busy_res)
    else $error("last byte flag without a byte");

  // a held input item is not lost while the result side stalls
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_start_q) && $stable(in_line_q))
    else $error("pending input item changed");

endmodule

`default_nettype wire

FILE: sim/tb_single_wire_sensor_reader_unit.sv
// self-checking testbench for the single-wire sensor reader unit
module tb_single_wire_sensor_reader_unit;
  import swsr_pkg::*;

  // register indexes that the block does not decode
  localparam logic [CfgIndexW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CfgIndexW-1:0] CFG_SPARE_B = 3'd7;
  localparam int unsigned MaxPrinted = 30;
  localparam int MaxBytesTb = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [0] start_request, [1] line_level
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [1:0] line_drive, [2] status_valid,
                                     // [4:3] response_status, [5] byte_valid,
                                     // [13:6] byte_data, [14] busy_res
  logic        m_axis_tlast;         // last_byte
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  single_wire_sensor_reader_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // line ticks waiting to be sent and results still to come
  logic [7:0] tick_q[$];
  res_t       result_q[$];
  int         pushed_cnt = 0;
  int         mismatch_cnt = 0;

  // idling and the long receiver hold-off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_req = 1'b0;
  int stall_left = 0;

  // shadow of the timing registers
  logic [LowTicksW-1:0]   set_start_low   = RST_START_LOW;
  logic [ShortTicksW-1:0] set_start_high  = RST_START_HIGH;
  logic [ShortTicksW-1:0] set_resp_first  = RST_RESP_FIRST;
  logic [ShortTicksW-1:0] set_resp_second = RST_RESP_SECOND;
  logic [ShortTicksW-1:0] set_bit_sample  = RST_BIT_SAMPLE;
  logic [ByteCountW-1:0]  set_bytes       = RST_BYTES;

  // shadow of the protocol state
  phase_e         ph = PH_IDLE;
  logic [20:0]    ticks = '0;
  logic [2:0]     bit_idx = '0;
  logic [7:0]     shreg = '0;
  int             byte_cnt = 0;

  // advance the delay counter, true once the delay has run out
  function automatic bit tick_up(input logic [20:0] lim);
    ticks = ticks + 21'd1;
    return ticks >= ((lim == 21'd0) ? 21'd1 : lim);
  endfunction

  // bytes actually read per transaction
  function automatic int bytes_total();
    if (set_bytes == 0) return 1;
    if (set_bytes > MaxBytesTb) return MaxBytesTb;
    return set_bytes;
  endfunction

  // one tick of the sensor reader
  function automatic res_t sensor_step(input logic start, input logic line);
    res_t r;
    r = '0;
    if (ph == PH_IDLE && start) begin
      ph = PH_START_LOW;
      ticks = '0;
      bit_idx = '0;
      shreg = '0;
      byte_cnt = 0;
    end
    if (ph != PH_IDLE) r.busy_res = 1'b1;
    case (ph)
      PH_IDLE: ;
      PH_START_LOW: begin
        r.line_drive = DRIVE_LOW;
        if (tick_up(set_start_low)) begin
          ph = PH_START_HIGH;
          ticks = '0;
        end
      end
      PH_START_HIGH: begin
        r.line_drive = DRIVE_HIGH;
        if (tick_up(set_start_high)) begin
          ph = PH_RESP_FIRST;
          ticks = '0;
        end
      end
      PH_RESP_FIRST: begin
        if (tick_up(set_resp_first)) begin
          ticks = '0;
          if (!line) begin
            ph = PH_RESP_SECOND;
          end else begin
            r.status_valid = 1'b1;
            r.response_status = RESP_NONE;
            ph = PH_RESP_WAIT_LOW;
          end
        end
      end
      PH_RESP_SECOND: begin
        if (tick_up(set_resp_second)) begin
          ticks = '0;
          r.status_valid = 1'b1;
          r.response_status = line ? RESP_OK : RESP_BAD;
          ph = PH_RESP_WAIT_LOW;
        end
      end
      PH_RESP_WAIT_LOW: begin
        if (!line) ph = PH_BIT_WAIT_HIGH;
      end
      PH_BIT_WAIT_HIGH: begin
        if (line) begin
          ph = PH_BIT_DELAY;
          ticks = '0;
        end
      end
      PH_BIT_DELAY: begin
        if (tick_up(set_bit_sample)) begin
          ticks = '0;
          shreg[3'd7 - bit_idx] = line;
          ph = PH_BIT_WAIT_LOW;
        end
      end
      PH_BIT_WAIT_LOW: begin
        if (!line) begin
          if (bit_idx == 3'd7) begin
            r.byte_valid = 1'b1;
            r.byte_data = shreg;
            bit_idx = '0;
            byte_cnt++;
            if (byte_cnt >= bytes_total()) begin
              r.last_byte = 1'b1;
              ph = PH_IDLE;
              byte_cnt = 0;
            end else begin
              ph = PH_BIT_WAIT_HIGH;
            end
          end else begin
            bit_idx = bit_idx + 3'd1;
            ph = PH_BIT_WAIT_HIGH;
          end
        end
      end
      default: ph = PH_IDLE;
    endcase
    return r;
  endfunction

  // print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_cnt < MaxPrinted)
      $display("%0t mismatch %0s: got %0h want %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // driver: the predictor runs on every accepted item
  always @(posedge clk_i) begin : driver
    logic [7:0] sent;
    bit offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sent = tick_q.pop_front();
        result_q.push_back(sensor_step(sent[0], sent[1]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = (tick_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        s_axis_tvalid <= offer;
        if (offer) s_axis_tdata <= tick_q[0];
      end
    end
  end

  // receiver ready, with a counted hold-off on request
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_req) begin
      stall_left <= 250;
      stall_req <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: compare each result item with the oldest prediction
  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.line_drive      = m_axis_tdata[1:0];
      got.status_valid    = m_axis_tdata[2];
      got.response_status = m_axis_tdata[4:3];
      got.byte_valid      = m_axis_tdata[5];
      got.byte_data       = m_axis_tdata[13:6];
      got.busy_res        = m_axis_tdata[14];
      got.last_byte       = m_axis_tlast;
      if (result_q.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata, 0);
      end else begin
        want = result_q.pop_front();
        if (got.line_drive !== want.line_drive)
          report_mismatch("line_drive", got.line_drive, want.line_drive);
        if (got.status_valid !== want.status_valid)
          report_mismatch("status_valid", got.status_valid, want.status_valid);
        if (got.response_status !== want.response_status)
          report_mismatch("response_status", got.response_status, want.response_status);
        if (got.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
        if (got.byte_data !== want.byte_data)
          report_mismatch("byte_data", got.byte_data, want.byte_data);
        if (got.last_byte !== want.last_byte)
          report_mismatch("last_byte", got.last_byte, want.last_byte);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", got.busy_res, want.busy_res);
      end
    end
  end

  function automatic void push_tick(input logic start, input logic line);
    tick_q.push_back({6'b0, line, start});
    pushed_cnt++;
  endfunction

  // random level on don't-care ticks of a noisy frame
  function automatic logic pick(input bit noisy, input logic level);
    return noisy ? logic'($urandom_range(1)) : level;
  endfunction

  function automatic int eff_ticks(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 22; recv_idle_pct = 53; end
      1: begin send_idle_pct = 53; recv_idle_pct = 22; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // wait until every tick is sent and every result has come back
  task automatic wait_idle();
    while (tick_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(negedge clk_i);
  endtask

  // register write, mirrored into the shadow copy once taken
  task automatic write_setting(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_LOW:    set_start_low = value;
      CFG_START_HIGH:   set_start_high = value[ShortTicksW-1:0];
      CFG_RESP_FIRST:   set_resp_first = value[ShortTicksW-1:0];
      CFG_RESP_SECOND:  set_resp_second = value[ShortTicksW-1:0];
      CFG_BIT_SAMPLE:   set_bit_sample = value[ShortTicksW-1:0];
      CFG_BYTES_PER_RD: set_bytes = value[ByteCountW-1:0];
      default: ;
    endcase
  endtask

  // all timing registers, with junk in the unused upper data bits
  task automatic write_timing(input int low_t, input int high_t, input int first_t,
                              input int second_t, input int sample_t, input int nbytes);
    write_setting(CFG_START_LOW, CfgDataW'(low_t));
    write_setting(CFG_START_HIGH, (CfgDataW'($urandom) & ~21'h3FF) | CfgDataW'(high_t));
    write_setting(CFG_RESP_FIRST, (CfgDataW'($urandom) & ~21'h3FF) | CfgDataW'(first_t));
    write_setting(CFG_RESP_SECOND, (CfgDataW'($urandom) & ~21'h3FF) | CfgDataW'(second_t));
    write_setting(CFG_BIT_SAMPLE, (CfgDataW'($urandom) & ~21'h3FF) | CfgDataW'(sample_t));
    write_setting(CFG_BYTES_PER_RD, (CfgDataW'($urandom) & ~21'hF) | CfgDataW'(nbytes));
  endtask

  // one well-formed transaction as the sensor would answer it, block idle at entry
  task automatic send_frame(input logic [1:0] resp, input logic [7:0] first_byte,
                            input bit noisy);
    int k;
    int i;
    int j;
    logic [7:0] value;
    push_tick(1'b1, pick(noisy, 1'b1));
    for (k = 1; k < eff_ticks(set_start_low) + eff_ticks(set_start_high); k++)
      push_tick(pick(noisy, 1'b0), pick(noisy, 1'b1));
    // response: low at the first sample, high at the second for ok
    for (k = 1; k < eff_ticks(set_resp_first); k++)
      push_tick(pick(noisy, 1'b0), pick(noisy, 1'b0));
    push_tick(pick(noisy, 1'b0), resp == RESP_NONE);
    if (resp != RESP_NONE) begin
      for (k = 1; k < eff_ticks(set_resp_second); k++)
        push_tick(pick(noisy, 1'b0), pick(noisy, 1'b1));
      push_tick(pick(noisy, 1'b0), resp == RESP_OK);
    end
    repeat ($urandom_range(3)) push_tick(pick(noisy, 1'b0), 1'b1);
    push_tick(pick(noisy, 1'b0), 1'b0);
    // data bits, most significant first
    for (i = 0; i < bytes_total(); i++) begin
      value = (i == 0) ? first_byte : 8'($urandom);
      for (j = 7; j >= 0; j--) begin
        repeat ($urandom_range(3)) push_tick(pick(noisy, 1'b0), 1'b0);
        push_tick(pick(noisy, 1'b0), 1'b1);
        for (k = 1; k < eff_ticks(set_bit_sample); k++)
          push_tick(pick(noisy, 1'b0), pick(noisy, 1'b1));
        push_tick(pick(noisy, 1'b0), value[j]);
        repeat ($urandom_range(3)) push_tick(pick(noisy, 1'b0), 1'b1);
        push_tick(pick(noisy, 1'b0), 1'b0);
      end
    end
  endtask

  // feed ticks that end whatever transaction is open
  task automatic settle();
    while (ph != PH_IDLE) begin
      @(negedge clk_i);
      case (ph)
        PH_RESP_WAIT_LOW, PH_BIT_WAIT_LOW: push_tick(1'b0, 1'b0);
        PH_BIT_WAIT_HIGH: push_tick(1'b0, 1'b1);
        default: push_tick(1'b0, logic'($urandom_range(1)));
      endcase
      wait_idle();
    end
  endtask

  // stimulus
  initial begin : stimulus
    int rand_items;
    int mark;
    int k;
    bit first_rand;
    rand_items = 0;
    first_rand = 1'b1;
    set_idling(0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle ticks under the reset timing
    @(negedge clk_i);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    wait_idle();

    // short start pulse, quick bits, one byte; response timing at its reset values
    write_setting(CFG_START_LOW, 21'd1);
    write_setting(CFG_BIT_SAMPLE, 21'd1);
    write_setting(CFG_BYTES_PER_RD, 21'd1);
    @(negedge clk_i);
    send_frame(RESP_OK, 8'h00, 1'b0);
    wait_idle();

    // every delay at its minimum, one byte per read
    write_timing(1, 1, 1, 1, 1, 1);
    @(negedge clk_i);
    send_frame(RESP_OK, 8'h81, 1'b0);
    send_frame(RESP_BAD, 8'h7E, 1'b1);
    send_frame(RESP_NONE, 8'h3C, 1'b0);
    wait_idle();

    // zero registers act as one
    write_timing(0, 0, 0, 0, 0, 0);
    @(negedge clk_i);
    send_frame(RESP_OK, 8'hC3, 1'b0);
    send_frame(RESP_NONE, 8'h18, 1'b1);
    wait_idle();

    // byte count above the maximum is clamped, then exactly the maximum
    write_timing(1, 1, 1, 1, 1, 15);
    @(negedge clk_i);
    send_frame(RESP_OK, 8'h5A, 1'b1);
    wait_idle();
    write_timing(1, 1, 1, 1, 1, 8);
    @(negedge clk_i);
    send_frame(RESP_BAD, 8'h99, 1'b0);
    wait_idle();

    // random transactions under random timing
    while (rand_items < 400) begin
      set_idling(rand_items < 200 ? 1 : 2);
      write_timing($urandom_range(0, 12), $urandom_range(0, 6), $urandom_range(0, 6),
                   $urandom_range(0, 6), $urandom_range(0, 6),
                   ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 2));
      @(negedge clk_i);
      mark = pushed_cnt;
      repeat ($urandom_range(1, 2)) begin
        k = $urandom_range(99);
        send_frame(k < 70 ? RESP_OK : (k < 85 ? RESP_BAD : RESP_NONE), 8'($urandom),
                   $urandom_range(3) == 0);
        repeat ($urandom_range(4)) push_tick(1'b0, logic'($urandom_range(1)));
      end
      // raw noise, may leave a transaction open
      if ($urandom_range(2) == 0)
        repeat ($urandom_range(5, 30))
          push_tick(logic'($urandom_range(1)), logic'($urandom_range(1)));
      if (first_rand) stall_req = 1'b1;
      first_rand = 1'b0;
      rand_items += pushed_cnt - mark;
      wait_idle();
      settle();
    end

    // longest start pulse and undecoded indexes, idle ticks only
    set_idling(2);
    write_timing(2097151, 1023, 1023, 1023, 1023, 15);
    write_setting(CFG_SPARE_A, CfgDataW'($urandom));
    write_setting(CFG_SPARE_B, CfgDataW'($urandom));
    @(negedge clk_i);
    repeat (20) push_tick(1'b0, logic'($urandom_range(1)));
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/swsr_pkg.sv
hdl/swsr_core.sv
hdl/single_wire_sensor_reader_unit.sv
sim/tb_single_wire_sensor_reader_unit.sv
